// ===== hw/rtl/pbt_pkg.sv =====
`default_nettype none

package pbt_pkg;

  // Breakpoint register bank
  localparam int BP_REGS    = 4;
  localparam int PC_W       = 16;
  localparam int IDX_W      = 8;
  localparam int IDX_CODES  = 1 << IDX_W;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int BP_SET_W   = PC_W + 1;

  // Item kinds carried on in_tuser
  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_READ    = 1'b1;

  typedef struct packed {
    logic            en;
    logic [PC_W-1:0] addr;
  } bp_setting_t;

  typedef bp_setting_t [BP_REGS-1:0] bp_bank_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pc_breakpoint_and_trace_unit_core.sv =====
// Each item passes through stage 1 and then the output register to out_tvalid.
// Throughput: one item per cycle while out_tready is high; the trace RAM takes
// one write or one read per item, and the breakpoint comparators all work in
// the accept cycle. Reset (synchronous, rst_n low) disables all breakpoints and
// empties both pipeline stages. Trace entries not yet written read as zero,
// tracked by the write position and a wrap flag, so no clearing pass is needed.
`default_nettype none

module pc_breakpoint_and_trace_unit_core
  import pbt_pkg::*;
#(
  parameter int NUM_BREAKPOINTS = 4,
  parameter int HISTORY_DEPTH   = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // [15:0] pc_value, [23:16] history_index
  input  wire logic                  in_tuser,   // [0] action
  // Result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [23:0]           out_tdata,  // [0] break_hit, [16:1] history_pc, rest 0
  // Configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int NUM_CMP = (NUM_BREAKPOINTS > BP_REGS) ? BP_REGS : NUM_BREAKPOINTS;

  bp_bank_t        bp_bank;
  logic            in_xfer;
  logic            in_act;
  logic [PC_W-1:0] in_pc;
  logic [IDX_W-1:0] in_idx;

  logic [AW-1:0]   pos_r;
  logic            wrapped_r;
  logic [AW-1:0]   idx_mod [IDX_CODES];
  logic [AW:0]     slot_sum;
  logic [AW-1:0]   slot;
  logic            slot_filled;
  logic            hit;

  logic            s1_valid_r;
  logic            s1_read_r;
  logic            s1_filled_r;
  logic            s1_hit_r;
  logic [PC_W-1:0] ram_rd_data;

  logic            out_valid_r;
  logic            out_hit_r;
  logic [PC_W-1:0] out_pc_r;
  logic            out_free;
  logic            s1_free;

  assign in_act  = in_tuser;
  assign in_pc   = in_tdata[PC_W-1:0];
  assign in_idx  = in_tdata[PC_W+IDX_W-1:PC_W];

  pbt_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .bp_bank     (bp_bank)
  );

  // Pipeline flow: output register frees when empty or taken
  assign out_free  = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || out_free;
  assign in_tready = s1_free;
  assign in_xfer   = in_tvalid && in_tready;

  // Constant table of history_index modulo depth
  for (genvar g = 0; g < IDX_CODES; g++) begin : g_idx_mod
    assign idx_mod[g] = AW'(g % HISTORY_DEPTH);
  end

  // Oldest-first slot: position plus reduced index, wrapped once
  always_comb begin
    slot_sum = {1'b0, pos_r} + {1'b0, idx_mod[in_idx]};
    if (slot_sum >= (AW+1)'(HISTORY_DEPTH)) begin
      slot = AW'(slot_sum - (AW+1)'(HISTORY_DEPTH));
    end else begin
      slot = slot_sum[AW-1:0];
    end
    slot_filled = wrapped_r || (slot < pos_r);
  end

  // Compare the observed PC with every enabled breakpoint
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_CMP; k++) begin
      if (bp_bank[k].en && (bp_bank[k].addr == in_pc)) begin
        hit = 1'b1;
      end
    end
  end

  pbt_trace_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_xfer && (in_act == ACT_OBSERVE)),
    .wr_addr (pos_r),
    .wr_data (in_pc),
    .rd_en   (in_xfer && (in_act == ACT_READ)),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  // Advance the write position on each observe transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else if (in_xfer && (in_act == ACT_OBSERVE)) begin
      if (pos_r == AW'(HISTORY_DEPTH - 1)) begin
        pos_r     <= '0;
        wrapped_r <= 1'b1;
      end else begin
        pos_r <= pos_r + AW'(1);
      end
    end
  end

  // Stage 1: wait for the RAM read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_read_r   <= (in_act == ACT_READ);
      s1_filled_r <= slot_filled;
      s1_hit_r    <= (in_act == ACT_OBSERVE) && hit;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_hit_r <= s1_hit_r;
      out_pc_r  <= (s1_read_r && s1_filled_r) ? ram_rd_data : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_pc_r, out_hit_r};

endmodule

`default_nettype wire

// ===== hw/rtl/pbt_cfg_regs.sv =====
`default_nettype none

module pbt_cfg_regs
  import pbt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output bp_bank_t                   bp_bank
);

  bp_bank_t              bp_r;
  logic [$clog2(BP_REGS)-1:0] reg_sel;
  logic                  wr_en;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Write the selected breakpoint register on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= '0;
    end else if (wr_en) begin
      bp_r[reg_sel] <= bp_setting_t'(cfg_pwdata[BP_SET_W-1:0]);
    end
  end

  // Read back the selected register, upper bits zero
  assign cfg_prdata = {{(CFG_DATA_W-BP_SET_W){1'b0}}, bp_r[reg_sel]};
  assign bp_bank    = bp_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pbt_trace_ram.sv =====
`default_nettype none

module pbt_trace_ram
  import pbt_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [PC_W-1:0] wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output logic      [PC_W-1:0] rd_data
);

  logic [PC_W-1:0] mem_r [DEPTH];
  logic [PC_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
